@@ src/tdf_pkg.sv @@
// tdf_pkg: shared types and constants of the task dispatcher fifo unit
// port widths, status and action codes, parameter defaults
// no dependencies
`default_nettype none

package tdf_pkg;

  localparam int NumWorkersDef = 8;
  localparam int QueueDepthDef = 16;
  localparam int TaskBitsDef   = 32;

  localparam int TaskW     = 32;
  localparam int WorkerIdW = 3;
  localparam int StatusW   = 3;
  localparam int CountW    = 5;

  typedef enum logic {
    ACT_SUBMIT = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_DISPATCHED = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_REJECTED   = 3'd2,
    ST_IDLED      = 3'd3,
    ST_BAD_FINISH = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_e;

endpackage

`default_nettype wire

@@ src/task_dispatcher_fifo_unit.sv @@
// task_dispatcher_fifo_unit: hands task handles to idle workers, queues the rest
// uses tdf_pkg for widths, status codes and state encoding
`default_nettype none

// One event is taken at a time. A submit gives its handle to the lowest-numbered
// idle worker, else appends it to the waiting queue, else rejects it. A finish
// from a busy worker hands it the oldest waiting handle, else marks it idle; a
// finish from an idle or out-of-range worker is reported as a bad finish with no
// change of state. Waiting handles live in a synchronous single-port-style RAM
// with a registered read. An event is registered on transfer and resolved in S_EXEC;
// a finish that pulls a handle from the queue passes through S_READ for the RAM read,
// and the result register may wait on out_ready_i. A new event is taken while a
// finished result still waits at the output.
module task_dispatcher_fifo_unit
  import tdf_pkg::*;
#(
  parameter int NUM_WORKERS = NumWorkersDef,
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int TASK_BITS   = TaskBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 action_i,
  input  wire logic [TaskW-1:0]     task_handle_i,
  input  wire logic [WorkerIdW-1:0] worker_id_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [StatusW-1:0]        status_o,
  output logic [WorkerIdW-1:0]      target_worker_o,
  output logic [TaskW-1:0]          dispatched_task_o,
  output logic [CountW-1:0]         waiting_count_o,
  output logic                      all_idle_o
);

  localparam int StoreBits = (TASK_BITS < TaskW) ? TASK_BITS : TaskW;
  localparam int SelW      = (NUM_WORKERS > (1 << WorkerIdW)) ? $clog2(NUM_WORKERS)
                                                              : WorkerIdW;
  localparam int PtrW      = $clog2(QUEUE_DEPTH);
  localparam int CntW      = $clog2(QUEUE_DEPTH + 1);

  state_e state_q, state_d;

  logic [NUM_WORKERS-1:0] busy_q, busy_d;
  logic [PtrW-1:0]        head_q, head_d;
  logic [PtrW-1:0]        tail_q, tail_d;
  logic [CntW-1:0]        fill_q, fill_d;

  logic                   act_q, act_d;
  logic [StoreBits-1:0]   handle_q, handle_d;
  logic [WorkerIdW-1:0]   wid_q, wid_d;

  logic [StoreBits-1:0]   queue_mem_q [QUEUE_DEPTH];
  logic [StoreBits-1:0]   rd_data_q;
  logic                   rd_en;
  logic                   wr_en;

  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  status_e                status_q, status_d;
  logic [WorkerIdW-1:0]   target_q, target_d;
  logic [TaskW-1:0]       task_q, task_d;
  logic [CountW-1:0]      count_q, count_d;
  logic                   idle_q, idle_d;

  logic                   free_found;
  logic [SelW-1:0]        free_idx;
  logic [SelW-1:0]        wid_ext;
  logic                   fin_busy;
  logic                   out_free;
  logic [CntW+CountW-1:0] fill_wide;

  // lowest idle worker
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = SelW'(i);
      end
    end
  end

  assign wid_ext = SelW'(wid_q);

  always_comb begin
    fin_busy = 1'b0;
    for (int i = 0; i < NUM_WORKERS; i++) begin
      if (busy_q[i] && (SelW'(i) == wid_ext)) begin
        fin_busy = 1'b1;
      end
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    busy_d   = busy_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    act_d    = act_q;
    handle_d = handle_q;
    wid_d    = wid_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    status_d = status_q;
    target_d = '0;
    task_d   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d    = action_i;
          handle_d = task_handle_i[StoreBits-1:0];
          wid_d    = worker_id_i;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (act_q == ACT_FINISH && fin_busy && fill_q != '0) begin
          rd_en   = 1'b1;
          state_d = S_READ;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (act_q == ACT_SUBMIT) begin
            if (free_found) begin
              for (int i = 0; i < NUM_WORKERS; i++) begin
                if (SelW'(i) == free_idx) begin
                  busy_d[i] = 1'b1;
                end
              end
              status_d = ST_DISPATCHED;
              target_d = free_idx[WorkerIdW-1:0];
              task_d   = TaskW'(handle_q);
            end else if (fill_q < CntW'(QUEUE_DEPTH)) begin
              wr_en    = 1'b1;
              tail_d   = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
              fill_d   = fill_q + CntW'(1);
              status_d = ST_QUEUED;
            end else begin
              status_d = ST_REJECTED;
            end
          end else begin
            target_d = wid_q;
            if (!fin_busy) begin
              status_d = ST_BAD_FINISH;
            end else begin
              for (int i = 0; i < NUM_WORKERS; i++) begin
                if (SelW'(i) == wid_ext) begin
                  busy_d[i] = 1'b0;
                end
              end
              status_d = ST_IDLED;
            end
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          head_d   = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
          fill_d   = fill_q - CntW'(1);
          status_d = ST_DISPATCHED;
          target_d = wid_q;
          task_d   = TaskW'(rd_data_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign fill_wide = (CntW + CountW)'(fill_d);
  assign count_d   = fill_wide[CountW-1:0];
  assign idle_d    = (busy_d == '0);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    handle_q <= handle_d;
    wid_q    <= wid_d;
    if (out_load) begin
      status_q <= status_d;
      target_q <= target_d;
      task_q   <= task_d;
      count_q  <= count_d;
      idle_q   <= idle_d;
    end
  end

  // waiting queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_mem_q[tail_q] <= handle_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= queue_mem_q[head_q];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign target_worker_o   = target_q;
  assign dispatched_task_o = task_q;
  assign waiting_count_o   = count_q;
  assign all_idle_o        = idle_q;

endmodule

`default_nettype wire
